>>> hdl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverter
// Element and result structs, fixed datapath widths and stage latencies.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  localparam int DATA_W = 32;   // one Q-format matrix element
  localparam int PROD_W = 64;   // product of two elements
  localparam int COF_W  = 65;   // signed 2x2 cofactor
  localparam int CMAG_W = 64;   // cofactor magnitude
  localparam int DET_W  = 97;   // signed determinant
  localparam int DMAG_W = 96;   // determinant magnitude
  localparam int THR_W  = 31;   // threshold register
  localparam int Q_W    = 33;   // quotient bits resolved by the divider

  // Stage counts of each part of the pipeline.
  localparam int COF_LAT  = 2;
  localparam int DET_LAT  = 6;
  localparam int LANE_LAT = Q_W + 4;
  localparam int PIPE_DEPTH = 1 + COF_LAT + DET_LAT + LANE_LAT;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;

  typedef struct packed {
    elem_t a_00;
    elem_t a_01;
    elem_t a_02;
    elem_t a_10;
    elem_t a_11;
    elem_t a_12;
    elem_t a_20;
    elem_t a_21;
    elem_t a_22;
  } mi3_in_t;

  typedef struct packed {
    elem_t inv_00;
    elem_t inv_01;
    elem_t inv_02;
    elem_t inv_10;
    elem_t inv_11;
    elem_t inv_12;
    elem_t inv_20;
    elem_t inv_21;
    elem_t inv_22;
    logic  invertible;
  } mi3_out_t;

  // Determinant status handed from the determinant unit to the lanes.
  typedef struct packed {
    logic [DMAG_W-1:0] dmag;
    logic              dneg;
    logic              ok;
  } mi3_det_t;

endpackage

`default_nettype wire

>>> hdl/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor: one signed 2x2 cofactor
// Two registered products followed by a registered exact difference.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_cofactor import mi3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire elem_t x_a,
  input  wire elem_t x_b,
  input  wire elem_t y_a,
  input  wire elem_t y_b,
  output cof_t       cof
);

  logic signed [PROD_W-1:0] px_r;
  logic signed [PROD_W-1:0] py_r;
  cof_t                     cof_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= PROD_W'(x_a) * PROD_W'(x_b);
      py_r  <= PROD_W'(y_a) * PROD_W'(y_b);
      cof_r <= COF_W'(px_r) - COF_W'(py_r);
    end
  end

  assign cof = cof_r;

endmodule

`default_nettype wire

>>> hdl/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det: determinant and singularity test
// Expands along row 0, splits each 32x64 product into two 32x32 halves,
// sums the terms and compares the magnitude with the scaled threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_det import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire elem_t            row0 [3],
  input  wire cof_t             cof0 [3],
  input  wire logic [THR_W-1:0] min_det,
  output mi3_det_t              det_o
);

  logic [DATA_W-1:0]        amag_r [3];
  logic [CMAG_W-1:0]        cmag_r [3];
  logic                     sg1_r  [3];
  logic [PROD_W-1:0]        pplo_r [3];
  logic [PROD_W-1:0]        pphi_r [3];
  logic                     sg2_r  [3];
  logic signed [DET_W-1:0]  term_r [3];
  logic signed [DET_W-1:0]  det_r;
  logic [DMAG_W-1:0]        dmag_r;
  logic                     dneg_r;
  mi3_det_t                 out_r;

  logic [DATA_W-1:0]        am    [3];
  logic [COF_W-1:0]         cm    [3];
  logic [DMAG_W-1:0]        tmag  [3];
  logic [DET_W-1:0]         dabs;
  logic [DMAG_W-1:0]        thr;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      am[c]   = row0[c][DATA_W-1] ? DATA_W'(-row0[c]) : DATA_W'(row0[c]);
      cm[c]   = cof0[c][COF_W-1] ? COF_W'(-cof0[c]) : COF_W'(cof0[c]);
      tmag[c] = DMAG_W'({pphi_r[c], {DATA_W{1'b0}}}) + DMAG_W'(pplo_r[c]);
    end
    dabs = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    thr  = {{(DMAG_W-THR_W){1'b0}}, min_det} << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        amag_r[c] <= am[c];
        cmag_r[c] <= cm[c][CMAG_W-1:0];
        sg1_r[c]  <= row0[c][DATA_W-1] ^ cof0[c][COF_W-1];
        pplo_r[c] <= PROD_W'(amag_r[c]) * PROD_W'(cmag_r[c][DATA_W-1:0]);
        pphi_r[c] <= PROD_W'(amag_r[c]) * PROD_W'(cmag_r[c][CMAG_W-1:DATA_W]);
        sg2_r[c]  <= sg1_r[c];
        term_r[c] <= sg2_r[c] ? -$signed({1'b0, tmag[c]}) : $signed({1'b0, tmag[c]});
      end
      det_r     <= term_r[0] + term_r[1] + term_r[2];
      dneg_r    <= det_r[DET_W-1];
      dmag_r    <= dabs[DMAG_W-1:0];
      out_r.dmag <= dmag_r;
      out_r.dneg <= dneg_r;
      out_r.ok   <= (dmag_r != '0) && (dmag_r >= thr);
    end
  end

  assign det_o = out_r;

endmodule

`default_nettype wire

>>> hdl/mi3_div_lane.sv
// ----------------------------------------------------------------------------
// mi3_div_lane: one inverse element
// Rounded restoring division of a cofactor by the determinant, one
// quotient bit per stage, then saturation and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div_lane import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     en,
  input  wire cof_t     adj,
  input  wire mi3_det_t det_i,
  output elem_t         res,
  output logic          ok_o
);

  localparam int NUM_W = CMAG_W + 1 + 2 * FRAC_BITS;
  localparam int NW    = (NUM_W > DMAG_W ? NUM_W : DMAG_W) + 1;
  localparam int RW    = NW + Q_W;

  // Prepare: magnitude and sign.
  logic [CMAG_W-1:0] amag_r;
  logic [DMAG_W-1:0] dmag0_r;
  logic              neg0_r;
  logic              ok0_r;
  // Numerator and doubled divisor.
  logic [RW-1:0]     n_r;
  logic [DMAG_W:0]   d1_r;
  logic              neg1_r;
  logic              ok1_r;
  // Divider stages.
  logic [RW-1:0]     rem_r [Q_W+1];
  logic [Q_W-1:0]    q_r   [Q_W+1];
  logic [DMAG_W:0]   d_r   [Q_W+1];
  logic              neg_r [Q_W+1];
  logic              ok_r  [Q_W+1];
  logic              ovf_r [Q_W+1];
  // Output.
  elem_t             res_r;
  logic              okf_r;

  logic [COF_W-1:0]  aabs;
  logic [Q_W-1:0]    lim;
  logic [Q_W-1:0]    mag;
  logic [Q_W-1:0]    sval;

  always_comb begin
    aabs = adj[COF_W-1] ? COF_W'(-adj) : COF_W'(adj);
    lim  = neg_r[Q_W] ? (Q_W'(1) << (DATA_W - 1)) : ((Q_W'(1) << (DATA_W - 1)) - Q_W'(1));
    mag  = (ovf_r[Q_W] || (q_r[Q_W] > lim)) ? lim : q_r[Q_W];
    sval = neg_r[Q_W] ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amag_r  <= aabs[CMAG_W-1:0];
      dmag0_r <= det_i.dmag;
      neg0_r  <= adj[COF_W-1] ^ det_i.dneg;
      ok0_r   <= det_i.ok;

      n_r    <= (RW'(amag_r) << (2 * FRAC_BITS + 1)) + RW'(dmag0_r);
      d1_r   <= {dmag0_r, 1'b0};
      neg1_r <= neg0_r;
      ok1_r  <= ok0_r;

      rem_r[0] <= n_r;
      q_r[0]   <= '0;
      d_r[0]   <= d1_r;
      neg_r[0] <= neg1_r;
      ok_r[0]  <= ok1_r;
      ovf_r[0] <= n_r >= (RW'(d1_r) << Q_W);

      res_r <= ok_r[Q_W] ? sval[DATA_W-1:0] : '0;
      okf_r <= ok_r[Q_W];
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int SH = Q_W - 1 - k;
    logic [RW-1:0] dsh;
    logic          take;

    assign dsh  = RW'(d_r[k]) << SH;
    assign take = rem_r[k] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? (rem_r[k] - dsh) : rem_r[k];
        q_r[k+1]   <= {q_r[k][Q_W-2:0], take};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
        ok_r[k+1]  <= ok_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign res  = res_r;
  assign ok_o = okf_r;

endmodule

`default_nettype wire

>>> hdl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse: streaming 3x3 matrix inverse by the adjugate
// Nine cofactor lanes, a determinant unit and nine divider lanes in one
// pipeline that takes a new matrix every cycle unless the output stalls.
// ----------------------------------------------------------------------------
// The block takes one full 3x3 matrix of signed fixed-point elements per
// cycle and returns its inverse, element by element rounded to nearest with
// ties away from zero and saturated to 32 bits, together with an invertible
// flag. A matrix whose determinant magnitude is below the threshold register
// (in the same fixed-point format) or is exactly zero is reported singular
// with all elements zero. The pipeline has PIPE_DEPTH = 46 register stages,
// counting the input register that loads at acceptance. The depth is set
// by the divider lanes, which resolve one of 33 quotient bits per stage.
// The whole pipeline moves as one: it advances whenever the output register
// is empty or being taken, and it freezes completely while a finished result
// waits under out_stall. Only then does in_stall follow out_stall in the same
// cycle, and empty stages are not filled meanwhile. Without output stalls a
// new matrix is taken every cycle. The threshold register must be written
// only while no request is in flight; cfg_ready is always high.
`default_nettype none

module matrix3x3_inverse import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Input requests.
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mi3_in_t          in_data,
  // Results.
  output logic                  out_valid,
  input  wire logic             out_stall,
  output mi3_out_t              out_data,
  // Threshold register write.
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [THR_W-1:0] cfg_data
);

  logic [THR_W-1:0]  min_det_r;
  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] v_nxt;
  mi3_in_t           m_r;
  logic              adv;

  elem_t             m      [3][3];
  cof_t              cof    [3][3];
  elem_t             row_d_r [COF_LAT][3];
  cof_t              cof_d_r [DET_LAT][3][3];
  cof_t              cof0   [3];
  mi3_det_t          det;
  elem_t             res    [3][3];
  logic              lane_ok [3][3];

  // The pipeline advances unless a result sits in the output stage and the
  // receiver holds it.
  assign adv       = !(v_r[PIPE_DEPTH-1] && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  assign v_nxt = {v_r[PIPE_DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      min_det_r <= THR_W'(1);
    end else begin
      if (adv) begin
        v_r <= v_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        min_det_r <= cfg_data;
      end
    end
  end

  // Input register and the matrix as a 3x3 array.
  always_ff @(posedge clk) begin
    if (adv) begin
      m_r <= in_data;
    end
  end

  assign m[0][0] = m_r.a_00;
  assign m[0][1] = m_r.a_01;
  assign m[0][2] = m_r.a_02;
  assign m[1][0] = m_r.a_10;
  assign m[1][1] = m_r.a_11;
  assign m[1][2] = m_r.a_12;
  assign m[2][0] = m_r.a_20;
  assign m[2][1] = m_r.a_21;
  assign m[2][2] = m_r.a_22;

  // Cofactor lanes. Cyclic row and column order gives each minor its
  // cofactor sign without a separate negation.
  for (genvar gr = 0; gr < 3; gr++) begin : g_cof_r
    for (genvar gc = 0; gc < 3; gc++) begin : g_cof_c
      localparam int R1 = (gr + 1) % 3;
      localparam int R2 = (gr + 2) % 3;
      localparam int C1 = (gc + 1) % 3;
      localparam int C2 = (gc + 2) % 3;
      mi3_cofactor u_cof (
        .clk (clk),
        .en  (adv),
        .x_a (m[R1][C1]),
        .x_b (m[R2][C2]),
        .y_a (m[R1][C2]),
        .y_b (m[R2][C1]),
        .cof (cof[gr][gc])
      );
    end
  end

  // Row 0 is delayed to meet its cofactors; all cofactors are delayed to
  // meet the determinant at the divider lanes.
  always_ff @(posedge clk) begin
    if (adv) begin
      row_d_r[0] <= m[0];
      for (int k = 1; k < COF_LAT; k++) begin
        row_d_r[k] <= row_d_r[k-1];
      end
      cof_d_r[0] <= cof;
      for (int k = 1; k < DET_LAT; k++) begin
        cof_d_r[k] <= cof_d_r[k-1];
      end
    end
  end

  assign cof0 = cof[0];

  mi3_det #(
    .FRAC_BITS (FRAC_BITS)
  ) u_det (
    .clk     (clk),
    .en      (adv),
    .row0    (row_d_r[COF_LAT-1]),
    .cof0    (cof0),
    .min_det (min_det_r),
    .det_o   (det)
  );

  // Divider lanes; the adjugate is the transposed cofactor matrix.
  for (genvar gr = 0; gr < 3; gr++) begin : g_div_r
    for (genvar gc = 0; gc < 3; gc++) begin : g_div_c
      mi3_div_lane #(
        .FRAC_BITS (FRAC_BITS)
      ) u_lane (
        .clk   (clk),
        .en    (adv),
        .adj   (cof_d_r[DET_LAT-1][gc][gr]),
        .det_i (det),
        .res   (res[gr][gc]),
        .ok_o  (lane_ok[gr][gc])
      );
    end
  end

  // Merge the lane results; the lanes' last registers are the output stage.
  assign out_valid           = v_r[PIPE_DEPTH-1];
  assign out_data.inv_00     = res[0][0];
  assign out_data.inv_01     = res[0][1];
  assign out_data.inv_02     = res[0][2];
  assign out_data.inv_10     = res[1][0];
  assign out_data.inv_11     = res[1][1];
  assign out_data.inv_12     = res[1][2];
  assign out_data.inv_20     = res[2][0];
  assign out_data.inv_21     = res[2][1];
  assign out_data.inv_22     = res[2][2];
  assign out_data.invertible = lane_ok[0][0];

  // A singular result carries zero elements; checked on six of the nine positions.
  a_singular_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.invertible |->
      out_data.inv_00 == '0 && out_data.inv_11 == '0 && out_data.inv_22 == '0 &&
      out_data.inv_01 == '0 && out_data.inv_12 == '0 && out_data.inv_20 == '0)
    else $error("singular result with nonzero element");

  // A held result freezes the whole pipeline's occupancy.
  a_hold_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(v_r))
    else $error("pipeline moved while output held");

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid && v_r == '0)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> test/matrix3x3_inverse_test.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_test: self-checking bench for the 3x3 matrix inverter
// Streams matrices through the block under several threshold settings and
// idle patterns, and checks every result against an inline fixed-point model.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse_test;
  import mi3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC      = 16;
  localparam int LIMIT_CYC = 400000;
  localparam int RAND_REQS = 270;   // random requests per phase, five phases

  // Idle patterns, one per phase in turn.
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  mi3_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  mi3_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;

  mi3_in_t    pending_matrices[$];
  mi3_out_t   expected_inverses[$];
  logic [THR_W-1:0] threshold = 1;
  idle_mode_t idle_mode = IDLE_NONE;
  int         cycle_count = 0;
  int         error_count = 0;
  int         matrices_sent = 0;
  int         inverses_checked = 0;
  int         singular_seen = 0;
  logic       in_taken = 1'b0;
  logic       running = 1'b0;

  matrix3x3_inverse #(.FRAC_BITS(FRAC)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Computes the expected inverse: exact cofactors and determinant, then each
  // transposed cofactor over the determinant, rounded half away from zero and
  // saturated to 32 bits. A determinant below the threshold, or exactly zero, gives all zeros.
  function automatic mi3_out_t invert_matrix(mi3_in_t m, logic [THR_W-1:0] thr);
    logic signed [127:0] e[3][3];
    logic signed [127:0] cof[3][3];
    logic signed [127:0] det;
    logic signed [127:0] adj;
    logic [127:0] dmag, amag, quot, lim, mag;
    logic [31:0]  elems[9];
    logic         dneg, ok, neg;
    mi3_out_t     res;
    e[0][0] = m.a_00; e[0][1] = m.a_01; e[0][2] = m.a_02;
    e[1][0] = m.a_10; e[1][1] = m.a_11; e[1][2] = m.a_12;
    e[2][0] = m.a_20; e[2][1] = m.a_21; e[2][2] = m.a_22;
    // Cyclic minors already carry the cofactor sign.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cof[r][c] = e[(r+1)%3][(c+1)%3] * e[(r+2)%3][(c+2)%3]
                  - e[(r+1)%3][(c+2)%3] * e[(r+2)%3][(c+1)%3];
      end
    end
    det = e[0][0] * cof[0][0] + e[0][1] * cof[0][1] + e[0][2] * cof[0][2];
    dneg = det[127];
    dmag = dneg ? -det : det;
    ok = (dmag != 0) && (dmag >= ({97'b0, thr} << (2 * FRAC)));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        elems[r*3+c] = '0;
        if (ok) begin
          adj  = cof[c][r];
          neg  = adj[127] != dneg;
          amag = adj[127] ? -adj : adj;
          quot = ((amag << (2 * FRAC + 1)) + dmag) / (dmag << 1);
          lim  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
          mag  = (quot > lim) ? lim : quot;
          elems[r*3+c] = neg ? -mag[31:0] : mag[31:0];
        end
      end
    end
    res = {elems[0], elems[1], elems[2], elems[3], elems[4], elems[5],
           elems[6], elems[7], elems[8], ok};
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
    error_count++;
  endtask

  // One element drawn from a few shapes: fully random bits, values near the
  // unit range, tiny values and the two extremes.
  function automatic elem_t random_element();
    case ($urandom_range(0, 9))
      0, 1, 2: return elem_t'($urandom());
      3:       return elem_t'($urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : 32'h8000_0000);
      4:       return elem_t'($urandom_range(0, 8)) - 4;
      default: return elem_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic mi3_in_t random_matrix();
    mi3_in_t m;
    m = {random_element(), random_element(), random_element(),
         random_element(), random_element(), random_element(),
         random_element(), random_element(), random_element()};
    // Some matrices are made nearly singular: the last row tracks the first
    // with a small disturbance, so the determinant is small next to its terms.
    if ($urandom_range(0, 3) == 0) begin
      m.a_20 = m.a_00 + elem_t'($urandom_range(0, 4)) - 2;
      m.a_21 = m.a_01 + elem_t'($urandom_range(0, 4)) - 2;
      m.a_22 = m.a_02 + elem_t'($urandom_range(0, 4)) - 2;
    end
    return m;
  endfunction

  function automatic mi3_in_t diag_matrix(elem_t d0, elem_t d1, elem_t d2);
    mi3_in_t m;
    m = '0;
    m.a_00 = d0;
    m.a_11 = d1;
    m.a_22 = d2;
    return m;
  endfunction

  // Directed requests: zero and identity matrices, the element extremes, a
  // determinant exactly at the default threshold, one just below it, and
  // positive and negative saturation.
  task automatic queue_directed_matrices();
    mi3_in_t m;
    pending_matrices.push_back('0);
    pending_matrices.push_back(diag_matrix(32'sh10000, 32'sh10000, 32'sh10000));
    pending_matrices.push_back(diag_matrix(-32'sh10000, 32'sh20000, 32'sh8000));
    pending_matrices.push_back({9{32'h7FFF_FFFF}});
    pending_matrices.push_back({9{32'h8000_0000}});
    pending_matrices.push_back(diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    pending_matrices.push_back(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    pending_matrices.push_back(diag_matrix(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    pending_matrices.push_back(diag_matrix(32'sh10000, 32'sh10000, 32'sh1));
    pending_matrices.push_back(diag_matrix(32'sh10000, 32'sh10000, -32'sh1));
    pending_matrices.push_back(diag_matrix(32'sh10000, 32'shFFFF, 32'sh1));
    pending_matrices.push_back(diag_matrix(32'sh1, 32'sh1, 32'sh1));
    pending_matrices.push_back(diag_matrix(32'sh20000, 32'sh10000, 32'sh10000));
    pending_matrices.push_back(diag_matrix(32'sh30000, 32'sh30000, 32'sh30000));
    m = diag_matrix(32'sh10000, 32'sh10000, 32'sh10000);
    m.a_01 = 32'sh7FFF_FFFF;
    m.a_12 = 32'sh8000_0000;
    pending_matrices.push_back(m);
    m = '0;
    m.a_02 = 32'sh10000;
    m.a_10 = -32'sh10000;
    m.a_21 = 32'sh10000;
    pending_matrices.push_back(m);
    m = {9{32'hFFFF_FFFF}};
    pending_matrices.push_back(m);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    threshold = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sample both channels at the rising edge. Our inputs change only at the
  // falling edge, so values read here are the ones the block sees.
  always @(posedge clk) begin
    cycle_count++;
    in_taken = in_valid && !in_stall && rst_n;
    if (in_taken) begin
      expected_inverses.push_back(invert_matrix(in_data, threshold));
      matrices_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_inverses.size() == 0) begin
        $display("UNEXPECTED result at cycle %0d: %h", cycle_count, out_data);
        error_count++;
      end else begin
        mi3_out_t want;
        want = expected_inverses.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (out_data[1+32*(8-k) +: 32] !== want[1+32*(8-k) +: 32])
            report_mismatch($sformatf("inv_%0d%0d", k / 3, k % 3),
                            out_data[1+32*(8-k) +: 32], want[1+32*(8-k) +: 32]);
        end
        if (out_data.invertible !== want.invertible)
          report_mismatch("invertible", out_data.invertible, want.invertible);
        if (!want.invertible) singular_seen++;
        inverses_checked++;
      end
    end
    if (cycle_count >= LIMIT_CYC) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_inverses.size());
      $display("matrix3x3_inverse test failed");
      $finish;
    end
  end

  // Request driver: a new matrix goes out at the falling edge once the last
  // one was taken, unless the sender idles this cycle. A held request keeps
  // its payload until accepted.
  always @(negedge clk) begin
    if (running && (!in_valid || in_taken)) begin
      if (pending_matrices.size() != 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 49) ||
            (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 35))) begin
        in_data  <= pending_matrices.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern follows the phase's idle mode.
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_stall <= $urandom_range(0, 99) < 49;
      IDLE_BOTH: out_stall <= $urandom_range(0, 99) < 35;
      default:   out_stall <= 1'b0;
    endcase
  end

  initial begin
    logic [THR_W-1:0] phase_thresholds[5];
    phase_thresholds[0] = 1;
    phase_thresholds[1] = 0;
    phase_thresholds[2] = 31'h0001_0000;
    phase_thresholds[3] = 31'h7FFF_FFFF;
    phase_thresholds[4] = THR_W'($urandom());
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      // The pipeline is empty here, so the threshold may change.
      write_threshold(phase_thresholds[ph]);
      idle_mode = idle_mode_t'(ph % 4);
      if (ph == 0) queue_directed_matrices();
      for (int n = 0; n < RAND_REQS; n++) pending_matrices.push_back(random_matrix());
      running = 1'b1;
      while (pending_matrices.size() != 0 || in_valid || expected_inverses.size() != 0)
        @(posedge clk);
      running = 1'b0;
      repeat (4) @(posedge clk);
    end
    idle_mode = IDLE_NONE;
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    $display("Sent %0d matrices over five threshold settings and four idle patterns;",
             matrices_sent);
    $display("checked %0d inverses, %0d of them singular.", inverses_checked, singular_seen);
    if (error_count == 0 && expected_inverses.size() == 0) begin
      $display("matrix3x3_inverse test passed");
    end else begin
      $display("matrix3x3_inverse test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
